/* rtl/core/position_fix_table_engine_assert.svh */
// assertion macros for the position fix table engine
`ifndef POSITION_FIX_TABLE_ENGINE_ASSERT_SVH
`define POSITION_FIX_TABLE_ENGINE_ASSERT_SVH

// property holds in the same cycle as its trigger
`define PFTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property holds in the cycle after its trigger
`define PFTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pfte_pkg.sv */
// shared types, codes and helpers of the position fix table engine
package pfte_pkg;

    localparam int HOPS_W = 9;
    localparam int KEY_W  = 10;

    localparam logic [1:0] CMD_RECEIVE = 2'd0;
    localparam logic [1:0] CMD_PURGE   = 2'd1;
    localparam logic [1:0] CMD_EMIT    = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    localparam logic [1:0] KIND_RECEIVE = 2'd0;
    localparam logic [1:0] KIND_PURGE   = 2'd1;
    localparam logic [1:0] KIND_RECORD  = 2'd2;

    localparam logic [1:0] ST_UPDATED  = 2'd0;
    localparam logic [1:0] ST_OWN_ID   = 2'd1;
    localparam logic [1:0] ST_NOT_NEW  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [2:0] CFG_FIXED_MODE    = 3'd0;
    localparam logic [2:0] CFG_OWN_ID        = 3'd1;
    localparam logic [2:0] CFG_OWN_LATITUDE  = 3'd2;
    localparam logic [2:0] CFG_OWN_LONGITUDE = 3'd3;
    localparam logic [2:0] CFG_STALE_SECONDS = 3'd4;
    localparam logic [2:0] CFG_PURGE_SECONDS = 3'd5;
    localparam logic [2:0] CFG_HOP_LIMIT     = 3'd6;

    localparam logic [HOPS_W-1:0] HOPS_NONE = '1;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PREP_EMIT,
        CELL_PREP_PURGE,
        CELL_SET_DROP,
        CELL_SET_HOPS,
        CELL_ROUND
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic              odd;
        logic              drop;
        logic [HOPS_W-1:0] hops;
    } t_cell_ctl;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] seq;
        logic [31:0] lat;
        logic [31:0] lon;
        logic [31:0] stamp;
    } t_slot;

    typedef struct packed {
        logic [31:0]       id;
        logic [31:0]       seq;
        logic [HOPS_W-1:0] hops;
        logic [31:0]       lat;
        logic [31:0]       lon;
    } t_rec;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] status;
        logic [5:0] count;
        t_rec       rec;
        logic       rec_valid;
        logic       last;
    } t_result;

    function automatic t_result make_result(logic [1:0] kind, logic [1:0] status,
                                            logic [5:0] count, t_rec rec,
                                            logic rec_valid, logic last);
        t_result r;
        r.kind      = kind;
        r.status    = status;
        r.count     = count;
        r.rec       = rec;
        r.rec_valid = rec_valid;
        r.last      = last;
        return r;
    endfunction

endpackage

/* rtl/core/pfte_slot_mem.sv */
// slot payload memory, one write port and one registered read port
module pfte_slot_mem
    import pfte_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_slot         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_slot         o_rdata
);

    t_slot r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/core/pfte_cells.sv */
// row of order cells: slot pointer, hops and sort key, odd-even transposition sort
module pfte_cells
    import pfte_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int IW    = 5,
    parameter int CW    = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [IW-1:0]     i_idx,
    input  logic [CW-1:0]     i_used,
    output logic [IW-1:0]     o_ptr,
    output logic [HOPS_W-1:0] o_hops
);

    logic [IW-1:0]     r_ptr  [DEPTH];
    logic [HOPS_W-1:0] r_hops [DEPTH];
    logic [KEY_W-1:0]  r_key  [DEPTH];
    logic [IW-1:0]     n_ptr  [DEPTH];
    logic [HOPS_W-1:0] n_hops [DEPTH];
    logic [KEY_W-1:0]  n_key  [DEPTH];

    assign o_ptr  = r_ptr[i_idx];
    assign o_hops = r_hops[i_idx];

    always_comb begin
        n_ptr  = r_ptr;
        n_hops = r_hops;
        n_key  = r_key;
        case (i_ctl.op)
            CELL_PREP_EMIT: begin
                // unused cells sort behind, hops biased so -1 comes first
                for (int k = 0; k < DEPTH; k++) begin
                    n_key[k] = {(CW'(k) >= i_used), ~r_hops[k][HOPS_W-1],
                                r_hops[k][HOPS_W-2:0]};
                end
            end
            CELL_PREP_PURGE: begin
                for (int k = 0; k < DEPTH; k++) begin
                    n_key[k] = {(CW'(k) >= i_used), {(KEY_W-1){1'b0}}};
                end
            end
            CELL_SET_DROP: begin
                n_key[i_idx][KEY_W-1] = i_ctl.drop;
            end
            CELL_SET_HOPS: begin
                n_hops[i_idx] = i_ctl.hops;
            end
            CELL_ROUND: begin
                // swap only on strictly greater keys, which keeps the sort stable
                for (int k = 0; k < DEPTH - 1; k++) begin
                    if (((k & 1) == int'(i_ctl.odd)) && (r_key[k] > r_key[k+1])) begin
                        n_ptr[k]    = r_ptr[k+1];
                        n_ptr[k+1]  = r_ptr[k];
                        n_hops[k]   = r_hops[k+1];
                        n_hops[k+1] = r_hops[k];
                        n_key[k]    = r_key[k+1];
                        n_key[k+1]  = r_key[k];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_ptr[k] <= IW'(k);
            end
        end else begin
            r_ptr <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hops <= n_hops;
        r_key  <= n_key;
    end

endmodule

/* rtl/core/position_fix_table_engine.sv */
// top level of the position fix table engine: sequencer and shared compare unit
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+---------------------------------------------
//  command   | start, busy               | i_command, i_fix_* , i_now_sec
//  result    | o_valid (one-cycle strobe)| o_kind, o_status, o_entry_count, o_out_*,
//            |                           | o_record_valid, o_last
//  config    | i_cfg_we                  | i_cfg_index, i_cfg_data
//
//  a transaction is taken when start is high and busy is low; busy then stays high
//  until the cycle in which the final result strobes
//  receive: ends at once on own id, else reads and compares each held slot in turn and,
//  when no id matches and the table is not full, claims a new slot
//  purge: a start step, a read and compare per held slot, then TABLE_SLOTS rounds of the sorter
//  emit: a start step, TABLE_SLOTS sort rounds, a read and compare per slot scanned, then a flush
//  synchronous reset resets control, the table bookkeeping, the configuration registers and the
//  slot pointers of the order cells; slot payload is written before it is ever read, so no clearing pass
//  the receiver cannot stall: each result is shown for exactly one cycle
module position_fix_table_engine
    import pfte_pkg::*;
#(
    parameter int TABLE_SLOTS  = 32,
    parameter int PACKET_FIXES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command transaction
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_fix_id,
    input  logic [31:0] i_fix_seq,
    input  logic [7:0]  i_fix_hops,
    input  logic [31:0] i_fix_lat,
    input  logic [31:0] i_fix_lon,
    input  logic [31:0] i_now_sec,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // result transaction
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_status,
    output logic [5:0]  o_entry_count,
    output logic [31:0] o_out_id,
    output logic [31:0] o_out_seq,
    output logic [8:0]  o_out_hops,
    output logic [31:0] o_out_lat,
    output logic [31:0] o_out_lon,
    output logic        o_record_valid,
    output logic        o_last
);

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int NW = $clog2(PACKET_FIXES + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RCV_START,
        S_RCV_RD,
        S_RCV_CMP,
        S_RCV_NEW,
        S_PRG_START,
        S_PRG_RD,
        S_PRG_CMP,
        S_EMT_START,
        S_SORT,
        S_EMT_RD,
        S_EMT_CMP,
        S_EMT_FLUSH
    } t_state;

    t_state r_state;

    // configuration registers
    logic        r_fixed_mode;
    logic [31:0] r_own_id;
    logic [31:0] r_own_lat;
    logic [31:0] r_own_lon;
    logic [15:0] r_stale;
    logic [15:0] r_purge;
    logic [7:0]  r_hop_limit;

    // table bookkeeping
    logic [CW-1:0] r_used;
    logic [31:0]   r_own_seq;

    // latched transaction
    logic [1:0]  r_cmd;
    logic [31:0] r_fix_id;
    logic [31:0] r_fix_seq;
    logic [7:0]  r_fix_hops;
    logic [31:0] r_fix_lat;
    logic [31:0] r_fix_lon;
    logic [31:0] r_now;

    // sequencer counters and the held-back record
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_cnt;
    logic [IW-1:0] r_round;
    logic [NW-1:0] r_n;
    logic          r_pend;
    t_rec          r_pend_rec;
    t_result       r_res;

    // shared unit signals
    t_slot             mem_rd;
    t_slot             mem_wdata;
    logic              mem_we;
    logic [IW-1:0]     cell_ptr;
    logic [HOPS_W-1:0] cell_hops;
    t_cell_ctl         cell_ctl;
    logic              id_match;
    logic              is_newer;
    logic              keep;
    logic              send;
    logic              new_upd;
    logic [32:0]       age;
    logic [NW-1:0]     n_n;
    t_rec              cand_rec;
    t_rec              zero_rec;
    t_rec              own_rec;

    assign busy = (r_state != S_IDLE);

    pfte_slot_mem #(
        .DEPTH (TABLE_SLOTS),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (cell_ptr),
        .i_wdata (mem_wdata),
        .i_raddr (cell_ptr),
        .o_rdata (mem_rd)
    );

    pfte_cells #(
        .DEPTH (TABLE_SLOTS),
        .IW    (IW),
        .CW    (CW)
    ) u_cells (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cell_ctl),
        .i_idx   (r_idx[IW-1:0]),
        .i_used  (r_used),
        .o_ptr   (cell_ptr),
        .o_hops  (cell_hops)
    );

    // shared compare unit: one slot per use
    always_comb begin
        id_match = (mem_rd.id == r_fix_id);
        is_newer = ($signed(r_fix_seq) > $signed(mem_rd.seq)) ||
                   ((r_fix_seq == mem_rd.seq) &&
                    ($signed({1'b0, r_fix_hops}) < $signed(cell_hops)));
        // signed age, so a time now that lies behind the stamp keeps the entry
        age      = {1'b0, r_now} - {1'b0, mem_rd.stamp};
        keep     = ($signed(age) <= $signed({17'b0, r_purge}));
        send     = (({1'b0, mem_rd.stamp} + {17'b0, r_stale}) > {1'b0, r_now}) &&
                   ($signed(cell_hops) < $signed({1'b0, r_hop_limit}));
        // a fresh slot holds seq -1, so only a non-negative seq is newer
        new_upd  = ~r_fix_seq[31];
        n_n      = r_n + NW'(send);
        cand_rec = '{id: mem_rd.id, seq: mem_rd.seq, hops: cell_hops + 1'b1,
                     lat: mem_rd.lat, lon: mem_rd.lon};
        zero_rec = '0;
        own_rec  = '{id: r_own_id, seq: r_own_seq, hops: '0,
                     lat: r_own_lat, lon: r_own_lon};
    end

    // memory write and cell control
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = '{id: r_fix_id, seq: r_fix_seq, lat: r_fix_lat, lon: r_fix_lon,
                      stamp: r_now};
        cell_ctl  = '{op: CELL_HOLD, odd: r_round[0], drop: ~keep,
                      hops: {1'b0, r_fix_hops}};
        case (r_state)
            S_RCV_CMP: begin
                if (id_match && is_newer) begin
                    mem_we      = 1'b1;
                    cell_ctl.op = CELL_SET_HOPS;
                end
            end
            S_RCV_NEW: begin
                mem_we      = 1'b1;
                cell_ctl.op = CELL_SET_HOPS;
                if (!new_upd) begin
                    mem_wdata     = '{id: r_fix_id, seq: '1, lat: '0, lon: '0, stamp: '0};
                    cell_ctl.hops = HOPS_NONE;
                end
            end
            S_PRG_START: cell_ctl.op = CELL_PREP_PURGE;
            S_PRG_CMP:   cell_ctl.op = CELL_SET_DROP;
            S_EMT_START: cell_ctl.op = CELL_PREP_EMIT;
            S_SORT:      cell_ctl.op = CELL_ROUND;
            default: begin
            end
        endcase
    end

    // sequencer, configuration and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fixed_mode <= 1'b0;
            r_own_id     <= '0;
            r_own_lat    <= '0;
            r_own_lon    <= '0;
            r_stale      <= '0;
            r_purge      <= '0;
            r_hop_limit  <= '0;
            r_used       <= '0;
            r_own_seq    <= 32'd1;
            r_pend       <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FIXED_MODE:    r_fixed_mode <= i_cfg_data[0];
                    CFG_OWN_ID:        r_own_id     <= i_cfg_data;
                    CFG_OWN_LATITUDE:  r_own_lat    <= i_cfg_data;
                    CFG_OWN_LONGITUDE: r_own_lon    <= i_cfg_data;
                    CFG_STALE_SECONDS: r_stale      <= i_cfg_data[15:0];
                    CFG_PURGE_SECONDS: r_purge      <= i_cfg_data[15:0];
                    CFG_HOP_LIMIT:     r_hop_limit  <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd      <= i_command;
                        r_fix_id   <= i_fix_id;
                        r_fix_seq  <= i_fix_seq;
                        r_fix_hops <= i_fix_hops;
                        r_fix_lat  <= i_fix_lat;
                        r_fix_lon  <= i_fix_lon;
                        r_now      <= i_now_sec;
                        r_idx      <= '0;
                        r_cnt      <= '0;
                        r_round    <= '0;
                        r_n        <= '0;
                        r_pend     <= 1'b0;
                        case (i_command)
                            CMD_RECEIVE: r_state <= S_RCV_START;
                            CMD_PURGE:   r_state <= S_PRG_START;
                            CMD_EMIT:    r_state <= S_EMT_START;
                            default:     r_state <= S_IDLE;
                        endcase
                    end
                end
                S_RCV_START: begin
                    if (r_fix_id == r_own_id) begin
                        o_valid <= 1'b1;
                        r_res   <= make_result(KIND_RECEIVE, ST_OWN_ID, 6'(r_used),
                                               zero_rec, 1'b0, 1'b1);
                        r_state <= S_IDLE;
                    end else if (r_used == '0) begin
                        r_state <= S_RCV_NEW;
                    end else begin
                        r_state <= S_RCV_RD;
                    end
                end
                S_RCV_RD: r_state <= S_RCV_CMP;
                S_RCV_CMP: begin
                    if (id_match) begin
                        o_valid <= 1'b1;
                        r_res   <= make_result(KIND_RECEIVE,
                                               is_newer ? ST_UPDATED : ST_NOT_NEW,
                                               6'(r_used), zero_rec, 1'b0, 1'b1);
                        r_state <= S_IDLE;
                    end else if ((r_idx + 1'b1) < r_used) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RCV_RD;
                    end else if (r_used == CW'(TABLE_SLOTS)) begin
                        o_valid <= 1'b1;
                        r_res   <= make_result(KIND_RECEIVE, ST_FULL, 6'(r_used),
                                               zero_rec, 1'b0, 1'b1);
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_used;
                        r_state <= S_RCV_NEW;
                    end
                end
                S_RCV_NEW: begin
                    // claim the slot behind the last held entry
                    r_used  <= r_used + 1'b1;
                    o_valid <= 1'b1;
                    r_res   <= make_result(KIND_RECEIVE, new_upd ? ST_UPDATED : ST_NOT_NEW,
                                           6'(r_used + 1'b1), zero_rec, 1'b0, 1'b1);
                    r_state <= S_IDLE;
                end
                S_PRG_START: begin
                    r_state <= (r_used == '0) ? S_SORT : S_PRG_RD;
                end
                S_PRG_RD: r_state <= S_PRG_CMP;
                S_PRG_CMP: begin
                    r_cnt <= r_cnt + CW'(keep);
                    if ((r_idx + 1'b1) < r_used) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_PRG_RD;
                    end else begin
                        r_state <= S_SORT;
                    end
                end
                S_EMT_START: begin
                    if (r_fixed_mode) begin
                        r_pend     <= 1'b1;
                        r_pend_rec <= own_rec;
                        r_n        <= NW'(1);
                        r_own_seq  <= r_own_seq + 32'd1;
                    end
                    r_state <= S_SORT;
                end
                S_SORT: begin
                    r_round <= r_round + 1'b1;
                    if (r_round == IW'(TABLE_SLOTS - 1)) begin
                        r_idx <= '0;
                        if (r_cmd == CMD_PURGE) begin
                            // kept entries now lead the row in their old order
                            r_used  <= r_cnt;
                            o_valid <= 1'b1;
                            r_res   <= make_result(KIND_PURGE, ST_UPDATED, 6'(r_cnt),
                                                   zero_rec, 1'b0, 1'b1);
                            r_state <= S_IDLE;
                        end else if ((r_used == '0) || (r_n == NW'(PACKET_FIXES))) begin
                            r_state <= S_EMT_FLUSH;
                        end else begin
                            r_state <= S_EMT_RD;
                        end
                    end
                end
                S_EMT_RD: r_state <= S_EMT_CMP;
                S_EMT_CMP: begin
                    // one record is held back so the final one can carry last
                    if (send) begin
                        if (r_pend) begin
                            o_valid <= 1'b1;
                            r_res   <= make_result(KIND_RECORD, ST_UPDATED, 6'(r_used),
                                                   r_pend_rec, 1'b1, 1'b0);
                        end
                        r_pend     <= 1'b1;
                        r_pend_rec <= cand_rec;
                    end
                    r_n <= n_n;
                    if (((r_idx + 1'b1) < r_used) && (n_n < NW'(PACKET_FIXES))) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_EMT_RD;
                    end else begin
                        r_state <= S_EMT_FLUSH;
                    end
                end
                S_EMT_FLUSH: begin
                    o_valid <= 1'b1;
                    r_res   <= make_result(KIND_RECORD, ST_UPDATED, 6'(r_used),
                                           r_pend ? r_pend_rec : zero_rec, r_pend, 1'b1);
                    r_pend  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_kind         = r_res.kind;
    assign o_status       = r_res.status;
    assign o_entry_count  = r_res.count;
    assign o_out_id       = r_res.rec.id;
    assign o_out_seq      = r_res.rec.seq;
    assign o_out_hops     = r_res.rec.hops;
    assign o_out_lat      = r_res.rec.lat;
    assign o_out_lon      = r_res.rec.lon;
    assign o_record_valid = r_res.rec_valid;
    assign o_last         = r_res.last;

`include "position_fix_table_engine_assert.svh"

    `PFTE_ASSERT_NOW(a_used_bound, 1'b1, r_used <= CW'(TABLE_SLOTS), "entry count overflow")
    `PFTE_ASSERT_NEXT(a_accept_busy, start && !busy && (i_command != CMD_NONE), busy,
        "accepted transaction did not raise busy")
    `PFTE_ASSERT_NOW(a_more_follow, o_valid && !o_last, busy,
        "engine went idle before the final result")
    `PFTE_ASSERT_NOW(a_single_result, o_valid && (o_kind != KIND_RECORD), o_last,
        "receive or purge result not marked final")

endmodule
